[sv/mrcr_pkg.sv]
// Shared types, constants and helpers for the Modbus response channel router.
`timescale 1ns / 1ps
package mrcr_pkg;

  // Field and register widths
  localparam int CH_COUNT_W  = 9;
  localparam int OFFSET_W    = 16;
  localparam int CHAN_W      = 8;
  localparam int VALUE_W     = 17;
  localparam int POS_W       = 9;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int BIT_IDX_W   = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_CHANNELS_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int BITS_PER_BYTE    = 8;

  localparam logic [POS_W-1:0]      POS_MAX       = 9'd511;
  localparam logic [CH_COUNT_W-1:0] CH_COUNT_RST  = 9'd9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_OFFSET  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_REGISTERS = 2'd2;

  // Modbus function codes
  localparam logic [BYTE_W-1:0] FC_READ_COILS    = 8'h01;
  localparam logic [BYTE_W-1:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [BYTE_W-1:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [BYTE_W-1:0] FC_READ_INPUT    = 8'h04;
  localparam logic [BYTE_W-1:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [BYTE_W-1:0] FC_WRITE_REG     = 8'h06;
  localparam logic [BYTE_W-1:0] FC_EXCEPTION     = 8'h80;

  localparam logic [15:0] COIL_ON = 16'hFF00;

  // One classified request handed from front to back
  typedef struct packed {
    logic [CHAN_W-1:0]  base;
    logic [COUNT_W-1:0] count;      // 0: frame-close marker only
    logic               coil;
    logic [BYTE_W-1:0]  bits;
    logic [VALUE_W-1:0] value;
    logic               frame_end;
  } job_t;

  // 16-bit register word, optionally sign extended to 17 bits
  function automatic logic [VALUE_W-1:0] reg_value(input logic [15:0] raw,
                                                   input logic        sign_en);
    reg_value = {sign_en & raw[15], raw};
  endfunction

endpackage

[sv/mrcr_ifs.sv]
// Channel interfaces: frame bytes in, channel updates out, configuration writes.
`timescale 1ns / 1ps
interface mrcr_byte_if import mrcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_end;
  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface mrcr_update_if import mrcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         channel;
  logic signed [VALUE_W-1:0] value;
  logic                      store_valid;
  logic                      frame_done;
  logic                      last;
  modport source (output valid, channel, value, store_valid, frame_done, last,
                  input ready);
  modport sink   (input valid, channel, value, store_valid, frame_done, last,
                  output ready);
endinterface

interface mrcr_cfg_if import mrcr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/modbus_response_channel_router_top.sv]
// Top level of the Modbus response channel router.
// A byte's first update passes the queue entry, current request and output register.
// Throughput: one byte per cycle while each makes at most one update and the update
// sink is ready; a coil byte makes up to eight updates and holds the emitter until
// all are out. Its single output register (one update per cycle) sets the rate.
// Reset: channel_count 9, offset 0, unsigned registers, frame state and queue cleared.
`timescale 1ns / 1ps
module modbus_response_channel_router_top import mrcr_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mrcr_byte_if.sink     frame,
  mrcr_cfg_if.sink      cfg,
  mrcr_update_if.source update
);

  logic push;
  job_t push_job;
  logic q_ready;
  logic pop;
  logic head_valid;
  job_t head;

  mrcr_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .push     (push),
    .push_job (push_job)
  );

  mrcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mrcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .update     (update)
  );

endmodule

[sv/mrcr_front.sv]
// Front end: config registers, frame parser and request classifier.
`timescale 1ns / 1ps
module mrcr_front import mrcr_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mrcr_byte_if.sink     frame,
  mrcr_cfg_if.sink      cfg,
  input  logic          q_ready,
  output logic          push,
  output job_t          push_job
);

  localparam logic [CH_COUNT_W-1:0] MAX_CH = CH_COUNT_W'(MAX_CHANNELS);

  // Configuration
  logic [CH_COUNT_W-1:0] channel_count;
  logic [OFFSET_W-1:0]   register_offset;
  logic                  signed_registers;

  // Frame state
  logic [POS_W-1:0]      byte_position, byte_position_next;
  logic [BYTE_W-1:0]     function_code, function_code_next;
  logic [BYTE_W-1:0]     declared_count, declared_count_next;
  logic [BYTE_W-1:0]     held_high_byte, held_high_byte_next;
  logic [CH_COUNT_W-1:0] next_coil_channel, next_coil_channel_next;
  logic [15:0]           echo_address, echo_address_next;

  logic                  accept;
  logic [CH_COUNT_W-1:0] lim;
  job_t                  job;

  assign cfg.ready   = 1'b1;
  assign frame.ready = q_ready;
  assign accept      = frame.valid && frame.ready;
  assign lim         = (channel_count < MAX_CH) ? channel_count : MAX_CH;

  // Classify the incoming byte and compute the next frame state
  always_comb begin
    logic [15:0]           raw;
    logic [POS_W-1:0]      rel;
    logic [CH_COUNT_W-1:0] room;
    logic [OFFSET_W:0]     diff;
    raw  = {held_high_byte, frame.data_byte};
    rel  = '0;
    room = '0;
    diff = '0;

    job           = '0;
    job.bits      = frame.data_byte;
    job.frame_end = frame.frame_end;

    function_code_next     = function_code;
    declared_count_next    = declared_count;
    next_coil_channel_next = next_coil_channel;
    echo_address_next      = echo_address;

    if (byte_position == POS_W'(1)) begin
      function_code_next = frame.data_byte;
    end else if (byte_position == POS_W'(2)) begin
      declared_count_next = frame.data_byte;
    end else if (byte_position >= POS_W'(3) && function_code < FC_EXCEPTION) begin
      unique case (function_code) inside
        FC_READ_COILS, FC_READ_DISCRETE: begin
          rel = byte_position - POS_W'(3);
          if (rel < {1'b0, declared_count} && next_coil_channel < lim) begin
            room      = lim - next_coil_channel;
            job.count = (room > CH_COUNT_W'(BITS_PER_BYTE)) ?
                        COUNT_W'(BITS_PER_BYTE) : room[COUNT_W-1:0];
            job.coil  = 1'b1;
            job.base  = next_coil_channel[CHAN_W-1:0];
            next_coil_channel_next = next_coil_channel + CH_COUNT_W'(job.count);
          end
        end
        FC_READ_HOLDING, FC_READ_INPUT: begin
          rel = byte_position - POS_W'(4);
          if (byte_position >= POS_W'(4) && !byte_position[0]) begin
            if (rel[POS_W-1:1] < (declared_count >> 1) &&
                {1'b0, rel[POS_W-1:1]} < lim) begin
              job.count = COUNT_W'(1);
              job.base  = rel[POS_W-1:1];
              job.value = reg_value(raw, signed_registers);
            end
          end
        end
        FC_WRITE_COIL, FC_WRITE_REG: begin
          diff = {1'b0, echo_address} - {1'b0, register_offset};
          if (byte_position == POS_W'(3)) begin
            echo_address_next = {declared_count, frame.data_byte};
          end else if (byte_position == POS_W'(5)) begin
            if (!diff[OFFSET_W] && diff[OFFSET_W-1:0] < OFFSET_W'(lim)) begin
              job.count = COUNT_W'(1);
              job.base  = diff[CHAN_W-1:0];
              job.value = (function_code == FC_WRITE_COIL) ?
                          VALUE_W'(raw == COIL_ON) : reg_value(raw, signed_registers);
            end
          end
        end
        default: ;
      endcase
    end

    held_high_byte_next = frame.data_byte;
    byte_position_next  = (byte_position == POS_MAX) ? POS_MAX :
                          byte_position + POS_W'(1);

    // Frame close clears all frame state
    if (frame.frame_end) begin
      byte_position_next     = '0;
      function_code_next     = '0;
      declared_count_next    = '0;
      held_high_byte_next    = '0;
      next_coil_channel_next = '0;
      echo_address_next      = '0;
    end
  end

  assign push     = accept && (job.count != '0 || frame.frame_end);
  assign push_job = job;

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= CH_COUNT_RST;
      register_offset   <= '0;
      signed_registers  <= 1'b0;
      byte_position     <= '0;
      function_code     <= '0;
      declared_count    <= '0;
      held_high_byte    <= '0;
      next_coil_channel <= '0;
      echo_address      <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_CHANNEL_COUNT:    channel_count    <= cfg.data[CH_COUNT_W-1:0];
          CFG_REGISTER_OFFSET:  register_offset  <= cfg.data[OFFSET_W-1:0];
          CFG_SIGNED_REGISTERS: signed_registers <= cfg.data[0];
          default: ;
        endcase
      end
      if (accept) begin
        byte_position     <= byte_position_next;
        function_code     <= function_code_next;
        declared_count    <= declared_count_next;
        held_high_byte    <= held_high_byte_next;
        next_coil_channel <= next_coil_channel_next;
        echo_address      <= echo_address_next;
      end
    end
  end

  // Coil cursor never passes the channel ceiling
  assert property (@(posedge clk) disable iff (rst) next_coil_channel <= MAX_CH)
    else $error("coil cursor beyond channel ceiling");
  // Start of frame means all frame state is clear
  assert property (@(posedge clk) disable iff (rst)
    byte_position == '0 |-> function_code == '0 && declared_count == '0 &&
                            next_coil_channel == '0)
    else $error("frame state not clear at frame start");
  // A request is only produced from an accepted byte
  assert property (@(posedge clk) disable iff (rst) push |-> q_ready)
    else $error("request pushed into full queue");

endmodule

[sv/mrcr_queue.sv]
// Short request queue between the front end and the update emitter.
`timescale 1ns / 1ps
module mrcr_queue import mrcr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic ready,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign ready      = fill != CNT_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("push into full queue");

endmodule

[sv/mrcr_back.sv]
// Back end: expands each request into channel updates, one per cycle while the sink is ready.
`timescale 1ns / 1ps
module mrcr_back import mrcr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  job_t          head,
  output logic          pop,
  mrcr_update_if.source update
);

  job_t                 cur;
  logic                 cur_valid;
  logic [BIT_IDX_W-1:0] k;
  logic                 can_emit;
  logic                 last_res;

  assign can_emit = cur_valid && (!update.valid || update.ready);
  assign last_res = (cur.count == '0) ||
                    (COUNT_W'(k) + COUNT_W'(1) == cur.count);
  assign pop      = head_valid && (!cur_valid || (can_emit && last_res));

  // Current request, bit index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      k            <= '0;
      update.valid <= 1'b0;
    end else begin
      if (pop) begin
        cur       <= head;
        cur_valid <= 1'b1;
        k         <= '0;
      end else if (can_emit && last_res) begin
        cur_valid <= 1'b0;
      end else if (can_emit) begin
        k <= k + BIT_IDX_W'(1);
      end

      if (can_emit) begin
        update.valid       <= 1'b1;
        update.channel     <= cur.base + CHAN_W'(k);
        update.value       <= $signed(cur.coil ? VALUE_W'(cur.bits[k]) : cur.value);
        update.store_valid <= cur.count != '0;
        update.frame_done  <= cur.frame_end && last_res;
        update.last        <= last_res;
      end else if (update.ready) begin
        update.valid <= 1'b0;
      end
    end
  end

  // Bit index stays inside the request's update count
  assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.count != '0 |-> COUNT_W'(k) < cur.count)
    else $error("bit index past update count");
  // A marker is always the closing result of its frame
  assert property (@(posedge clk) disable iff (rst)
    update.valid && !update.store_valid |-> update.frame_done && update.last)
    else $error("marker without frame close");
  // An emitted result shows up in the output register
  assert property (@(posedge clk) disable iff (rst) can_emit |=> update.valid)
    else $error("emitted result lost");

endmodule
